[rtl/core/sha1_pkg.sv]
package sha1_pkg;

  // block geometry
  localparam int unsigned DigestWords   = 5;
  localparam int unsigned SchedWords    = 16;
  localparam int unsigned BlockBytes    = 64;
  localparam int unsigned LenBytePos    = 56;
  localparam int unsigned Rounds        = 80;
  localparam int unsigned RoundsPerStep = 20;

  localparam logic [7:0] PadMark = 8'h80;

  typedef logic [31:0] word_t;

  // round function group
  typedef enum logic [1:0] {
    PH_CHOOSE  = 2'd0,
    PH_PARITY1 = 2'd1,
    PH_MAJ     = 2'd2,
    PH_PARITY2 = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_ADD,
    ST_OUT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic       absorb;
    logic       pad;
    logic       round;
    phase_t     phase;
    logic       add;
    logic       clear;
    logic [2:0] word_sel;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic fill_last;
    logic len_byte;
  } sts_t;

  // initial chaining value
  function automatic word_t init_word(input logic [2:0] idx);
    word_t w;
    unique case (idx)
      3'd0:    w = 32'h67452301;
      3'd1:    w = 32'hefcdab89;
      3'd2:    w = 32'h98badcfe;
      3'd3:    w = 32'h10325476;
      3'd4:    w = 32'hc3d2e1f0;
      default: w = '0;
    endcase
    return w;
  endfunction

  // round constant per group
  function automatic word_t round_k(input phase_t ph);
    word_t k;
    unique case (ph)
      PH_CHOOSE:  k = 32'h5a827999;
      PH_PARITY1: k = 32'h6ed9eba1;
      PH_MAJ:     k = 32'h8f1bbcdc;
      PH_PARITY2: k = 32'hca62c1d6;
      default:    k = '0;
    endcase
    return k;
  endfunction

endpackage

[rtl/core/sha1_ctrl.sv]
module sha1_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  input  logic            in_has_byte,
  input  logic            in_end,
  output logic            in_tready,
  output logic            out_tvalid,
  input  logic            out_tready,
  output logic            out_tlast,
  output logic [2:0]      word_index,
  input  sha1_pkg::sts_t  sts,
  output sha1_pkg::cmd_t  cmd
);

  sha1_pkg::state_t state_r, state_nxt;
  logic [6:0]       cnt_r, cnt_nxt;
  logic             pad_mode_r, pad_mode_nxt;
  logic             done_r, done_nxt;
  logic             last_round;
  logic             last_word;

  assign last_round = (cnt_r == 7'(sha1_pkg::Rounds - 1));
  assign last_word  = (cnt_r[2:0] == 3'(sha1_pkg::DigestWords - 1));

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= sha1_pkg::ST_IDLE;
      cnt_r      <= '0;
      pad_mode_r <= 1'b0;
      done_r     <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cnt_r      <= cnt_nxt;
      pad_mode_r <= pad_mode_nxt;
      done_r     <= done_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    pad_mode_nxt = pad_mode_r;
    done_nxt     = done_r;
    unique case (state_r)
      sha1_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          pad_mode_nxt = in_end;
          if (in_has_byte && sts.fill_last) begin
            state_nxt = sha1_pkg::ST_ROUND;
            cnt_nxt   = '0;
          end else if (in_end) begin
            state_nxt = sha1_pkg::ST_PAD;
          end
        end
      end
      sha1_pkg::ST_PAD: begin
        // one padding byte per cycle until the block fills
        if (sts.fill_last) begin
          state_nxt = sha1_pkg::ST_ROUND;
          cnt_nxt   = '0;
          done_nxt  = sts.len_byte;
        end
      end
      sha1_pkg::ST_ROUND: begin
        cnt_nxt = cnt_r + 7'd1;
        if (last_round) begin
          state_nxt = sha1_pkg::ST_ADD;
        end
      end
      sha1_pkg::ST_ADD: begin
        cnt_nxt = '0;
        if (done_r) begin
          state_nxt = sha1_pkg::ST_OUT;
        end else if (pad_mode_r) begin
          state_nxt = sha1_pkg::ST_PAD;
        end else begin
          state_nxt = sha1_pkg::ST_IDLE;
        end
      end
      sha1_pkg::ST_OUT: begin
        if (out_tready) begin
          if (last_word) begin
            state_nxt    = sha1_pkg::ST_IDLE;
            cnt_nxt      = '0;
            pad_mode_nxt = 1'b0;
            done_nxt     = 1'b0;
          end else begin
            cnt_nxt = cnt_r + 7'd1;
          end
        end
      end
      default: state_nxt = sha1_pkg::ST_IDLE;
    endcase
  end

  // outputs and datapath commands
  always_comb begin
    cmd          = '0;
    in_tready    = (state_r == sha1_pkg::ST_IDLE);
    out_tvalid   = (state_r == sha1_pkg::ST_OUT);
    out_tlast    = (state_r == sha1_pkg::ST_OUT) && last_word;
    word_index   = cnt_r[2:0];
    cmd.word_sel = cnt_r[2:0];
    cmd.absorb   = (state_r == sha1_pkg::ST_IDLE) && in_tvalid && in_has_byte;
    cmd.pad      = (state_r == sha1_pkg::ST_PAD);
    cmd.round    = (state_r == sha1_pkg::ST_ROUND);
    cmd.add      = (state_r == sha1_pkg::ST_ADD);
    cmd.clear    = (state_r == sha1_pkg::ST_OUT) && out_tready && last_word;
    priority if (cnt_r < 7'(sha1_pkg::RoundsPerStep)) begin
      cmd.phase = sha1_pkg::PH_CHOOSE;
    end else if (cnt_r < 7'(2 * sha1_pkg::RoundsPerStep)) begin
      cmd.phase = sha1_pkg::PH_PARITY1;
    end else if (cnt_r < 7'(3 * sha1_pkg::RoundsPerStep)) begin
      cmd.phase = sha1_pkg::PH_MAJ;
    end else begin
      cmd.phase = sha1_pkg::PH_PARITY2;
    end
  end

endmodule

[rtl/core/sha1_dp.sv]
module sha1_dp (
  input  logic            clk,
  input  logic            rst_n,
  input  sha1_pkg::cmd_t  cmd,
  input  logic [7:0]      in_byte,
  output sha1_pkg::sts_t  sts,
  output logic [31:0]     digest_word
);

  sha1_pkg::word_t w_r     [sha1_pkg::SchedWords];
  sha1_pkg::word_t w_nxt   [sha1_pkg::SchedWords];
  sha1_pkg::word_t chain_r [sha1_pkg::DigestWords];
  sha1_pkg::word_t chain_nxt [sha1_pkg::DigestWords];
  sha1_pkg::word_t work_r  [sha1_pkg::DigestWords];
  sha1_pkg::word_t work_nxt [sha1_pkg::DigestWords];
  logic [5:0]      fill_r, fill_nxt;
  logic [60:0]     len_r, len_nxt;
  logic            mark_r, mark_nxt;
  logic            lenph_r, lenph_nxt;

  logic            len_sel;
  logic [63:0]     bit_len;
  logic [7:0]      len_byte_val;
  logic [7:0]      pad_byte;
  logic [7:0]      wr_byte;
  logic            wr_en;
  sha1_pkg::word_t fn;
  sha1_pkg::word_t tmp;
  sha1_pkg::word_t sched_mix;
  sha1_pkg::word_t sched_new;
  sha1_pkg::word_t va, vb, vc, vd, ve;

  // padding byte selection
  assign len_sel = mark_r && (fill_r >= 6'(sha1_pkg::LenBytePos)) &&
                   ((fill_r == 6'(sha1_pkg::LenBytePos)) || lenph_r);
  assign bit_len      = {len_r, 3'b000};
  assign len_byte_val = bit_len[{~fill_r[2:0], 3'b000} +: 8];
  assign pad_byte     = !mark_r ? sha1_pkg::PadMark : (len_sel ? len_byte_val : 8'h00);
  assign wr_byte      = cmd.pad ? pad_byte : in_byte;
  assign wr_en        = cmd.absorb || cmd.pad;

  assign sts.fill_last = (fill_r == 6'(sha1_pkg::BlockBytes - 1));
  assign sts.len_byte  = len_sel;

  // round logic
  assign va = work_r[0];
  assign vb = work_r[1];
  assign vc = work_r[2];
  assign vd = work_r[3];
  assign ve = work_r[4];

  always_comb begin
    unique case (cmd.phase)
      sha1_pkg::PH_CHOOSE: fn = (vb & vc) | (~vb & vd);
      sha1_pkg::PH_MAJ:    fn = (vb & vc) | (vb & vd) | (vc & vd);
      default:             fn = vb ^ vc ^ vd;
    endcase
  end

  assign tmp = {va[26:0], va[31:27]} + fn + ve + sha1_pkg::round_k(cmd.phase) + w_r[0];

  // schedule expansion over the sliding window
  assign sched_mix = w_r[13] ^ w_r[8] ^ w_r[2] ^ w_r[0];
  assign sched_new = {sched_mix[30:0], sched_mix[31]};

  always_comb begin
    for (int i = 0; i < sha1_pkg::SchedWords; i++) begin
      w_nxt[i] = w_r[i];
    end
    if (wr_en) begin
      w_nxt[fill_r[5:2]][{~fill_r[1:0], 3'b000} +: 8] = wr_byte;
    end else if (cmd.round) begin
      for (int i = 0; i < sha1_pkg::SchedWords - 1; i++) begin
        w_nxt[i] = w_r[i + 1];
      end
      w_nxt[sha1_pkg::SchedWords - 1] = sched_new;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < sha1_pkg::SchedWords; i++) begin
      w_r[i] <= w_nxt[i];
    end
  end

  // chaining value, working variables and message bookkeeping
  always_comb begin
    for (int i = 0; i < sha1_pkg::DigestWords; i++) begin
      chain_nxt[i] = chain_r[i];
      work_nxt[i]  = work_r[i];
    end
    fill_nxt  = fill_r;
    len_nxt   = len_r;
    mark_nxt  = mark_r;
    lenph_nxt = lenph_r;

    if (wr_en) begin
      fill_nxt = fill_r + 6'd1;
    end
    if (cmd.absorb) begin
      len_nxt = len_r + 61'd1;
    end
    if (cmd.pad) begin
      mark_nxt = 1'b1;
      if (len_sel) begin
        lenph_nxt = 1'b1;
      end
    end
    if (cmd.round) begin
      work_nxt[0] = tmp;
      work_nxt[1] = va;
      work_nxt[2] = {vb[1:0], vb[31:2]};
      work_nxt[3] = vc;
      work_nxt[4] = vd;
    end
    if (cmd.add) begin
      for (int i = 0; i < sha1_pkg::DigestWords; i++) begin
        chain_nxt[i] = chain_r[i] + work_r[i];
        work_nxt[i]  = chain_r[i] + work_r[i];
      end
    end
    if (cmd.clear) begin
      for (int i = 0; i < sha1_pkg::DigestWords; i++) begin
        chain_nxt[i] = sha1_pkg::init_word(3'(i));
        work_nxt[i]  = sha1_pkg::init_word(3'(i));
      end
      fill_nxt  = '0;
      len_nxt   = '0;
      mark_nxt  = 1'b0;
      lenph_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < sha1_pkg::DigestWords; i++) begin
        chain_r[i] <= sha1_pkg::init_word(3'(i));
        work_r[i]  <= sha1_pkg::init_word(3'(i));
      end
      fill_r  <= '0;
      len_r   <= '0;
      mark_r  <= 1'b0;
      lenph_r <= 1'b0;
    end else begin
      for (int i = 0; i < sha1_pkg::DigestWords; i++) begin
        chain_r[i] <= chain_nxt[i];
        work_r[i]  <= work_nxt[i];
      end
      fill_r  <= fill_nxt;
      len_r   <= len_nxt;
      mark_r  <= mark_nxt;
      lenph_r <= lenph_nxt;
    end
  end

  // digest word readout
  always_comb begin
    if (cmd.word_sel < 3'(sha1_pkg::DigestWords)) begin
      digest_word = chain_r[cmd.word_sel];
    end else begin
      digest_word = '0;
    end
  end

endmodule

[rtl/core/sha1_hash_engine_top.sv]
// Streaming SHA-1 hasher. Each input transfer carries one message byte (in_tuser high) and/or
// ends the message (in_tlast high); an empty transfer with in_tlast set closes the message
// as it stands. Each full 64-byte block is then compressed by an 80-round loop, one round per
// cycle, followed by the chaining update; no input is taken while a block is processed. At
// message end the padding bytes are written one per cycle (up to 72, with one extra
// compression when the length no longer fits), after which the digest leaves as five 32-bit
// transfers, most significant word first, with out_tuser giving the word position and
// out_tlast marking the fifth.
// No new input is taken until the final digest word has been transferred.
module sha1_hash_engine_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // [0] has_byte
  input  logic        in_tlast,   // end_of_message
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] digest_word
  output logic [2:0]  out_tuser,  // [2:0] word_index
  output logic        out_tlast   // last_word
);

  sha1_pkg::cmd_t cmd;
  sha1_pkg::sts_t sts;

  // sequencing of absorb, padding, rounds and readout
  sha1_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_has_byte (in_tuser),
    .in_end      (in_tlast),
    .in_tready   (in_tready),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tlast   (out_tlast),
    .word_index  (out_tuser),
    .sts         (sts),
    .cmd         (cmd)
  );

  // block buffer, schedule, compression and chaining value
  sha1_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .in_byte     (in_tdata),
    .sts         (sts),
    .digest_word (out_tdata)
  );

`ifndef SYNTHESIS
  // input and output sides never open together
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input ready while digest is being shown");

  // final word transfer returns the block to taking input
  a_back_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tlast) |=> in_tready)
    else $error("block did not return to idle after digest");

  // last marker sits exactly on the fifth word
  a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tlast == (out_tuser == 3'(sha1_pkg::DigestWords - 1))))
    else $error("last marker on wrong digest word");

  // word index advances by one per word transfer
  a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && !out_tlast) |=>
      (out_tvalid && (out_tuser == $past(out_tuser) + 3'd1)))
    else $error("digest word index skipped");
`endif

endmodule
